// ===== hw/rtl/kst_pkg.sv =====
package kst_pkg;

    localparam int MaxVertices = 16;
    localparam int MaxEdges    = 64;
    localparam int VtxW        = 4;
    localparam int WeightW     = 16;
    localparam int TotalW      = 20;
    localparam int CountW      = 7;
    localparam int MaxResults  = 15;
    localparam int ResCntW     = 4;
    localparam int StepW       = 5;

    typedef struct packed {
        logic [VtxW-1:0]           src;
        logic [VtxW-1:0]           dst;
        logic signed [WeightW-1:0] weight;
    } edge_t;

    typedef struct packed {
        logic ins;
        logic pop;
    } cell_ctl_t;

    typedef struct packed {
        logic [VtxW-1:0]           src;
        logic [VtxW-1:0]           dst;
        logic signed [WeightW-1:0] weight;
        logic                      edge_valid;
        logic signed [TotalW-1:0]  total;
        logic                      last;
    } result_t;

endpackage

// ===== hw/rtl/kst_sort_cell.sv =====
module kst_sort_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  kst_pkg::cell_ctl_t ctl,
    input  kst_pkg::edge_t     new_edge,
    input  logic               left_keep,
    input  logic               left_valid,
    input  kst_pkg::edge_t     left_edge,
    input  logic               right_valid,
    input  kst_pkg::edge_t     right_edge,
    output logic               keep,
    output logic               valid,
    output kst_pkg::edge_t     edge_q
);

    logic           valid_reg;
    logic           valid_next;
    kst_pkg::edge_t edge_reg;
    kst_pkg::edge_t edge_next;

    // stays put when holding an edge not heavier than the new one (ties keep arrival order)
    assign keep   = valid_reg && (edge_reg.weight <= new_edge.weight);
    assign valid  = valid_reg;
    assign edge_q = edge_reg;

    always_comb begin
        valid_next = valid_reg;
        edge_next  = edge_reg;
        if (ctl.pop) begin
            valid_next = right_valid;
            edge_next  = right_edge;
        end else if (ctl.ins && !keep) begin
            if (left_keep) begin
                valid_next = 1'b1;
                edge_next  = new_edge;
            end else begin
                valid_next = left_valid;
                edge_next  = left_edge;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        edge_reg <= edge_next;
    end

endmodule

// ===== hw/rtl/kst_link_table.sv =====
module kst_link_table (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      clr,
    input  logic                      we,
    input  logic [kst_pkg::VtxW-1:0]  wr_addr,
    input  logic [kst_pkg::VtxW-1:0]  wr_data,
    input  logic [kst_pkg::VtxW-1:0]  rd_addr,
    output logic [kst_pkg::VtxW-1:0]  rd_data
);

    logic [kst_pkg::VtxW-1:0] link_reg [kst_pkg::MaxVertices];

    assign rd_data = link_reg[rd_addr];

    always_ff @(posedge aclk) begin
        if (!aresetn || clr) begin
            for (int i = 0; i < kst_pkg::MaxVertices; i++) begin
                link_reg[i] <= kst_pkg::VtxW'(i);
            end
        end else if (we) begin
            link_reg[wr_addr] <= wr_data;
        end
    end

endmodule

// ===== hw/rtl/kruskal_spanning_tree_core.sv =====
// channel  | dir | tdata (low bit up)                                   | tlast
// s_       | in  | src_vertex, dst_vertex, edge_weight                  | last_edge
// m_       | out | tree_src, tree_dst, tree_weight, edge_valid,         | last_result
//          |     | total_weight, overflow, 2 zero bits                  |
// loading accepts one edge per cycle: each edge drops into its sorted place in a row of
// 64 cells in the cycle it arrives; edges past the 64th are dropped and flag overflow.
// after the last edge, each stored edge is popped, its two ends are walked to their roots
// in the link table and it is kept or skipped; a pop on an empty row then closes the run.
// reset clears counters, links and cell valid bits at once. a stalled result output
// holds the run at its next result.
module kruskal_spanning_tree_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // src_vertex, dst_vertex, edge_weight
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // tree_src, tree_dst, tree_weight, edge_valid,
                                   // total_weight, overflow
    output logic        m_tlast
);

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_POP   = 3'd1;
    localparam logic [2:0] S_FSRC  = 3'd2;
    localparam logic [2:0] S_FDST  = 3'd3;
    localparam logic [2:0] S_JUDGE = 3'd4;
    localparam logic [2:0] S_FLUSH = 3'd5;

    logic [2:0]                        state_reg, state_next;
    logic [kst_pkg::CountW-1:0]        count_reg, count_next;
    logic                              dropped_reg, dropped_next;
    logic [kst_pkg::ResCntW-1:0]       res_cnt_reg, res_cnt_next;
    kst_pkg::edge_t                    cur_reg, cur_next;
    logic [kst_pkg::VtxW-1:0]          walk_reg, walk_next;
    logic [kst_pkg::StepW-1:0]         steps_reg, steps_next;
    logic [kst_pkg::VtxW-1:0]          root_a_reg, root_a_next;
    logic signed [kst_pkg::TotalW-1:0] total_reg, total_next;
    kst_pkg::result_t                  pend_reg, pend_next;
    logic                              pend_valid_reg, pend_valid_next;
    kst_pkg::result_t                  out_reg, out_next;
    logic                              out_ovf_reg, out_ovf_next;
    logic                              m_valid_reg, m_valid_next;

    kst_pkg::cell_ctl_t       ctl;
    kst_pkg::edge_t           new_edge;
    logic                     lk_clr, lk_we;
    logic [kst_pkg::VtxW-1:0] lk_rd;
    logic                     out_load, out_free, walk_done, s_accept;

    logic           c_keep  [kst_pkg::MaxEdges];
    logic           c_valid [kst_pkg::MaxEdges];
    kst_pkg::edge_t c_edge  [kst_pkg::MaxEdges];

    assign new_edge.src    = s_tdata[3:0];
    assign new_edge.dst    = s_tdata[7:4];
    assign new_edge.weight = s_tdata[23:8];

    genvar g;
    generate
        for (g = 0; g < kst_pkg::MaxEdges; g++) begin : g_cell
            logic           lk, lv, rv;
            kst_pkg::edge_t le, re;
            if (g == 0) begin : g_head
                assign lk = 1'b1;
                assign lv = 1'b1;
                assign le = new_edge;
            end else begin : g_mid
                assign lk = c_keep[g-1];
                assign lv = c_valid[g-1];
                assign le = c_edge[g-1];
            end
            if (g == kst_pkg::MaxEdges - 1) begin : g_tail
                assign rv = 1'b0;
                assign re = '0;
            end else begin : g_body
                assign rv = c_valid[g+1];
                assign re = c_edge[g+1];
            end
            kst_sort_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctl         (ctl),
                .new_edge    (new_edge),
                .left_keep   (lk),
                .left_valid  (lv),
                .left_edge   (le),
                .right_valid (rv),
                .right_edge  (re),
                .keep        (c_keep[g]),
                .valid       (c_valid[g]),
                .edge_q      (c_edge[g])
            );
        end
    endgenerate

    kst_link_table u_links (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clr     (lk_clr),
        .we      (lk_we),
        .wr_addr (root_a_reg),
        .wr_data (walk_reg),
        .rd_addr (walk_reg),
        .rd_data (lk_rd)
    );

    assign s_tready  = (state_reg == S_LOAD);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign walk_done = (lk_rd == walk_reg) ||
                       (steps_reg == kst_pkg::StepW'(kst_pkg::MaxVertices));

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        dropped_next    = dropped_reg;
        res_cnt_next    = res_cnt_reg;
        cur_next        = cur_reg;
        walk_next       = walk_reg;
        steps_next      = steps_reg;
        root_a_next     = root_a_reg;
        total_next      = total_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_ovf_next    = out_ovf_reg;
        out_load        = 1'b0;
        ctl             = '0;
        lk_we           = 1'b0;
        lk_clr          = 1'b0;
        case (state_reg)
            S_LOAD: begin
                if (s_accept) begin
                    if (count_reg < kst_pkg::CountW'(kst_pkg::MaxEdges)) begin
                        ctl.ins    = 1'b1;
                        count_next = count_reg + 1'b1;
                    end else begin
                        dropped_next = 1'b1;
                    end
                    if (s_tlast) begin
                        state_next = S_POP;
                    end
                end
            end
            S_POP: begin
                if (!c_valid[0]) begin
                    state_next = S_FLUSH;
                end else begin
                    cur_next   = c_edge[0];
                    ctl.pop    = 1'b1;
                    walk_next  = c_edge[0].src;
                    steps_next = '0;
                    state_next = S_FSRC;
                end
            end
            S_FSRC: begin
                if (walk_done) begin
                    root_a_next = walk_reg;
                    walk_next   = cur_reg.dst;
                    steps_next  = '0;
                    state_next  = S_FDST;
                end else begin
                    walk_next  = lk_rd;
                    steps_next = steps_reg + 1'b1;
                end
            end
            S_FDST: begin
                if (walk_done) begin
                    state_next = S_JUDGE;
                end else begin
                    walk_next  = lk_rd;
                    steps_next = steps_reg + 1'b1;
                end
            end
            S_JUDGE: begin
                // walk_reg now holds the destination root
                if (root_a_reg != walk_reg &&
                    res_cnt_reg < kst_pkg::ResCntW'(kst_pkg::MaxResults)) begin
                    if (!pend_valid_reg || out_free) begin
                        lk_we      = 1'b1;
                        total_next = total_reg + kst_pkg::TotalW'(cur_reg.weight);
                        if (pend_valid_reg) begin
                            out_load     = 1'b1;
                            out_next     = pend_reg;
                            out_ovf_next = dropped_reg;
                        end
                        pend_next.src        = cur_reg.src;
                        pend_next.dst        = cur_reg.dst;
                        pend_next.weight     = cur_reg.weight;
                        pend_next.edge_valid = 1'b1;
                        pend_next.total      = total_next;
                        pend_next.last       = 1'b0;
                        pend_valid_next      = 1'b1;
                        res_cnt_next         = res_cnt_reg + 1'b1;
                        state_next           = S_POP;
                    end
                end else begin
                    state_next = S_POP;
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    out_ovf_next = dropped_reg;
                    if (pend_valid_reg) begin
                        out_next = pend_reg;
                    end else begin
                        out_next = '0;
                    end
                    out_next.last   = 1'b1;
                    lk_clr          = 1'b1;
                    count_next      = '0;
                    dropped_next    = 1'b0;
                    res_cnt_next    = '0;
                    total_next      = '0;
                    pend_valid_next = 1'b0;
                    state_next      = S_LOAD;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_LOAD;
            count_reg      <= '0;
            dropped_reg    <= 1'b0;
            res_cnt_reg    <= '0;
            total_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            dropped_reg    <= dropped_next;
            res_cnt_reg    <= res_cnt_next;
            total_reg      <= total_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        cur_reg     <= cur_next;
        walk_reg    <= walk_next;
        steps_reg   <= steps_next;
        root_a_reg  <= root_a_next;
        pend_reg    <= pend_next;
        out_reg     <= out_next;
        out_ovf_reg <= out_ovf_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {2'b00, out_ovf_reg, out_reg.total, out_reg.edge_valid,
                       out_reg.weight, out_reg.dst, out_reg.src};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= kst_pkg::CountW'(kst_pkg::MaxEdges))
        else $error("edge count beyond capacity");

    a_result_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        res_cnt_reg <= kst_pkg::ResCntW'(kst_pkg::MaxResults))
        else $error("too many tree edges");

    a_no_pending_in_load: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_LOAD |-> !pend_valid_reg && res_cnt_reg == '0)
        else $error("leftover run state while loading");

    a_flush_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_FLUSH && out_free |=> state_reg == S_LOAD && m_tvalid && m_tlast)
        else $error("run did not close with a final transaction");

endmodule

// ===== bench/kruskal_spanning_tree_core_test.sv =====
`timescale 1ns / 1ps

module kruskal_spanning_tree_core_test;
    import kst_pkg::*;

    typedef struct {
        edge_t e;
        logic  last;
    } edge_item_t;

    typedef struct {
        logic [VtxW-1:0]           src;
        logic [VtxW-1:0]           dst;
        logic signed [WeightW-1:0] weight;
        logic                      edge_valid;
        logic signed [TotalW-1:0]  total;
        logic                      overflow;
        logic                      last;
    } tree_result_t;

    localparam int IdleLimit = 40000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // src_vertex, dst_vertex, edge_weight
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // tree_src, tree_dst, tree_weight, edge_valid,
                            // total_weight, overflow
    logic        m_tlast;

    kruskal_spanning_tree_core u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    edge_item_t   pending_edges[$];
    edge_t        graph_edges[$];
    logic         graph_dropped;
    tree_result_t tree_expected[$];
    edge_item_t   cur_edge;
    int           send_gap;
    int           recv_stall;
    logic         send_burst;
    logic         recv_burst;
    int           idle_cycles;
    int           errors;
    logic [VtxW-1:0] link_table[MaxVertices];

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int draw_wait(logic burst);
        if (burst) return 0;
        return $urandom_range(0, 18);
    endfunction

    function automatic logic [VtxW-1:0] find_root(logic [VtxW-1:0] v);
        int steps;
        steps = 0;
        while (link_table[v] != v && steps < MaxVertices) begin
            v = link_table[v];
            steps++;
        end
        return v;
    endfunction

    // stores one accepted edge; on the last edge works out the whole tree
    task automatic build_tree(edge_item_t it);
        edge_t                    sorted[$];
        edge_t                    key;
        tree_result_t             r;
        logic [VtxW-1:0]          r1;
        logic [VtxW-1:0]          r2;
        logic signed [TotalW-1:0] total;
        int                       n;
        int                       j;
        if (graph_edges.size() < MaxEdges) graph_edges.insert(graph_edges.size(), it.e);
        else graph_dropped = 1'b1;
        if (!it.last) return;
        sorted = graph_edges;
        // stable insertion sort keeps arrival order among equal weights
        for (int i = 1; i < sorted.size(); i++) begin
            key = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1].weight > key.weight) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = key;
        end
        for (int v = 0; v < MaxVertices; v++) link_table[v] = VtxW'(v);
        n = 0;
        total = '0;
        foreach (sorted[i]) begin
            r1 = find_root(sorted[i].src);
            r2 = find_root(sorted[i].dst);
            if (r1 != r2 && n < MaxResults) begin
                link_table[r1] = r2;
                total += sorted[i].weight;
                r.src = sorted[i].src;
                r.dst = sorted[i].dst;
                r.weight = sorted[i].weight;
                r.edge_valid = 1'b1;
                r.total = total;
                r.overflow = graph_dropped;
                r.last = 1'b0;
                tree_expected.insert(tree_expected.size(), r);
                n++;
            end
        end
        if (n == 0) begin
            r = '{src: '0, dst: '0, weight: '0, edge_valid: 1'b0, total: '0,
                  overflow: graph_dropped, last: 1'b1};
            tree_expected.insert(tree_expected.size(), r);
        end else begin
            tree_expected[tree_expected.size()-1].last = 1'b1;
        end
        graph_edges.delete();
        graph_dropped = 1'b0;
    endtask

    // edge driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) build_tree(cur_edge);
            if (!s_tvalid || s_tready) begin
                if (send_gap != 0) begin
                    s_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pending_edges.size() != 0) begin
                    cur_edge = pending_edges.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {cur_edge.e.weight, cur_edge.e.dst, cur_edge.e.src};
                    s_tlast <= cur_edge.last;
                    if ($urandom_range(0, 29) == 0) send_burst = ~send_burst;
                    send_gap <= draw_wait(send_burst);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        logic         ready_n;
        logic         got;
        int           stall;
        tree_result_t act;
        tree_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_stall <= 0;
            idle_cycles <= 0;
        end else begin
            got = m_tvalid && m_tready;
            ready_n = m_tready;
            if (got) begin
                act.src = m_tdata[3:0];
                act.dst = m_tdata[7:4];
                act.weight = m_tdata[23:8];
                act.edge_valid = m_tdata[24];
                act.total = m_tdata[44:25];
                act.overflow = m_tdata[45];
                act.last = m_tlast;
                if (tree_expected.size() == 0) begin
                    $display("%0t: unexpected result, actual %p", $time, act);
                    errors++;
                end else begin
                    want = tree_expected.pop_front();
                    if (act != want || m_tdata[47:46] != 2'b00) begin
                        $display("%0t: result mismatch, expected %p, actual %p pad %b",
                                 $time, want, act, m_tdata[47:46]);
                        errors++;
                    end
                end
                if ($urandom_range(0, 29) == 0) recv_burst = ~recv_burst;
                stall = draw_wait(recv_burst);
                recv_stall <= stall;
                if (stall != 0) ready_n = 1'b0;
            end else if (!m_tready) begin
                if (recv_stall != 0) recv_stall <= recv_stall - 1;
                else ready_n = 1'b1;
            end
            m_tready <= ready_n;
            if (got || (s_tvalid && s_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic add_edge(int s, int d, int w, bit last);
        edge_item_t it;
        it.e.src = VtxW'(s);
        it.e.dst = VtxW'(d);
        it.e.weight = WeightW'(w);
        it.last = last;
        pending_edges.insert(pending_edges.size(), it);
    endtask

    task automatic add_random_graph(int edges, int verts, bit narrow);
        int w;
        for (int i = 0; i < edges; i++) begin
            w = narrow ? $urandom_range(0, 7) - 3 : $signed(16'($urandom));
            add_edge($urandom_range(0, verts - 1), $urandom_range(0, verts - 1), w,
                     i == edges - 1);
        end
    endtask

    initial begin
        int total_items;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        send_burst = 1'b0;
        recv_burst = 1'b1;
        graph_dropped = 1'b0;
        errors = 0;

        // lone self loop gives the empty tree
        add_edge(5, 5, 100, 1);
        // field extremes
        add_edge(0, 15, -32768, 1);
        add_edge(15, 0, 32767, 0);
        add_edge(15, 15, -1, 0);
        // equal weights keep arrival order
        add_edge(1, 2, 7, 0);
        add_edge(2, 3, 7, 0);
        add_edge(1, 3, 7, 0);
        add_edge(3, 1, 7, 1);
        // full chain over all vertices: fifteen results
        for (int v = 0; v < 15; v++) add_edge(v, v + 1, 32767 - v, v == 14);
        // store full: the extra edges are dropped
        add_random_graph(70, 16, 0);
        // last edge arrives with the store already full
        add_random_graph(65, 6, 1);

        total_items = pending_edges.size();
        while (total_items < 400) begin
            int n;
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 12);
            add_random_graph(n, $urandom_range(2, 16), $urandom_range(0, 1) == 1);
            total_items += n;
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_edges.size() != 0 || s_tvalid || tree_expected.size() != 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (errors == 0 && tree_expected.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== kruskal_spanning_tree_core.f =====
hw/rtl/kst_pkg.sv
hw/rtl/kst_sort_cell.sv
hw/rtl/kst_link_table.sv
hw/rtl/kruskal_spanning_tree_core.sv
bench/kruskal_spanning_tree_core_test.sv
